// ===== rtl/keyframe_curve_evaluator_top_macros.svh =====
// Assertion macros shared by the curve evaluator checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef KEYFRAME_CURVE_EVALUATOR_TOP_MACROS_SVH
`define KEYFRAME_CURVE_EVALUATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFCE_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFCE_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kfce_pkg.sv =====
// Shared types and constants for the keyframe curve evaluator.
// No dependencies; imported by every module of the block.
package kfce_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = 6;
    localparam int USED_W     = 7;
    localparam int KIND_W     = 3;
    localparam int VAL_W      = 32;

    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;
    localparam int Q_CW       = 2;

    localparam int MUL_AW     = 34;
    localparam int MUL_BW     = 20;
    localparam int PROD_W     = 54;
    localparam int ACC_W      = 56;
    localparam int WIDE_W     = 40;

    localparam logic [KIND_W-1:0] KIND_LIN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HERM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_KLIN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_KHERM = 3'd4;
    localparam logic [KIND_W-1:0] KIND_KSTEP = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic REG_KIND = 1'b0;
    localparam logic REG_USED = 1'b1;

    localparam logic [USED_W-1:0] USED_RESET = 7'd2;

    typedef struct packed {
        logic                    func;
        logic [PT_AW-1:0]        index;
        logic signed [VAL_W-1:0] word;
        logic signed [VAL_W-1:0] pos;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [USED_W-1:0] used;
    } t_cfg;

endpackage

// ===== rtl/kfce_front.sv =====
// Front end: accepts stream words and queues them for the evaluation engine.
// Depends on kfce_pkg.
module kfce_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kfce_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_q_valid,
    output kfce_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import kfce_pkg::*;

    t_item            r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_CW-1:0]  r_cnt;
    logic             push, pop;

    assign o_ready   = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/kfce_back.sv =====
// Evaluation engine: point store, breakpoint search, divider, shared multiplier
// and output register. Depends on kfce_pkg.
module kfce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  kfce_pkg::t_item i_q_item,
    output logic            o_q_pop,
    input  kfce_pkg::t_cfg  i_cfg,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [31:0]     o_value,
    output logic            o_fb
);
    import kfce_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_START = 21'h000002,
        S_NT    = 21'h000004,
        S_LPRE  = 21'h000008,
        S_LA    = 21'h000010,
        S_LB    = 21'h000020,
        S_LM    = 21'h000040,
        S_HX    = 21'h000080,
        S_HX2   = 21'h000100,
        S_HX3   = 21'h000200,
        S_HB    = 21'h000400,
        S_HM    = 21'h000800,
        S_HACC  = 21'h001000,
        S_K0    = 21'h002000,
        S_KL    = 21'h004000,
        S_KS    = 21'h008000,
        S_KX0   = 21'h010000,
        S_DIV   = 21'h020000,
        S_RDRES = 21'h040000,
        S_SAT   = 21'h080000,
        S_DONE  = 21'h100000
    } t_state;

    t_state r_state, n_state;

    // point store
    logic [VAL_W-1:0]        r_mem [MAX_POINTS];
    logic signed [VAL_W-1:0] r_rdata;
    logic [PT_AW-1:0]        mem_raddr;
    logic                    mem_we;

    // shared multiplier
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [VAL_W-1:0]  r_t, n_t;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [USED_W-1:0]        r_used, n_used;
    logic [PT_AW-1:0]         r_n, n_n, r_i, n_i, r_j, n_j;
    logic [16:0]              r_x, n_x, r_x2, n_x2, r_x3, n_x3;
    logic signed [MUL_BW-1:0] r_h [4];
    logic signed [MUL_BW-1:0] n_h [4];
    logic [1:0]               r_k, n_k;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [VAL_W-1:0]  r_a, n_a, r_x1, n_x1;
    logic [33:0]              r_rem, n_rem;
    logic [32:0]              r_dx, n_dx;
    logic [15:0]              r_q, n_q;
    logic [3:0]               r_cnt, n_cnt;
    logic signed [WIDE_W-1:0] r_wide, n_wide;
    logic [VAL_W-1:0]         r_res, n_res;
    logic                     r_fb, n_fb;
    logic                     r_ovalid;
    logic [VAL_W-1:0]         r_oval;
    logic                     r_ofb;
    logic                     out_load;

    // helpers
    logic [USED_W-1:0] used_sat;
    logic [PT_AW-1:0]  half, third, stride, last_key, addr_a, addr_b, hm_addr, hm_next;
    logic [12:0]       used43;
    logic [7:0]        last_ext;
    logic [16:0]       t_clamp;
    logic signed [MUL_BW-1:0] sx, sx2, sx3;
    logic signed [32:0] dx, dt;
    logic [33:0]        rem2;
    logic               ge;
    logic [37:0]        seg;

    function automatic logic [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > WIDE_W'(32'sh7fffffff)) begin
            r = 32'h7fffffff;
        end else if (v < -WIDE_W'(33'sh080000000)) begin
            r = 32'h80000000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PT_AW-1:0] herm_addr(input logic [KIND_W-1:0] kind,
                                                    input logic [PT_AW-1:0] j,
                                                    input logic [1:0] k);
        logic [PT_AW-1:0] a;
        if (kind == KIND_KHERM) begin
            a = j + PT_AW'(1) + PT_AW'(k) + ((k[1]) ? PT_AW'(1) : PT_AW'(0));
        end else begin
            a = j + PT_AW'(k);
        end
        return a;
    endfunction

    assign used_sat = (i_cfg.used > USED_W'(MAX_POINTS)) ? USED_W'(MAX_POINTS) : i_cfg.used;
    assign half     = r_used[USED_W-1:1];
    assign used43   = 13'(r_used) * 13'd43;
    assign third    = used43[12:7];
    assign stride   = (r_kind == KIND_KHERM) ? PT_AW'(3) : PT_AW'(2);
    assign last_ext = (r_kind == KIND_KHERM) ? (8'(r_n) * 8'd3 - 8'd3) : (8'(r_n) * 8'd2 - 8'd2);
    assign last_key = last_ext[PT_AW-1:0];
    assign addr_a   = (r_kind == KIND_KLIN) ? r_j + PT_AW'(1) : r_j;
    assign addr_b   = (r_kind == KIND_KLIN) ? r_j + PT_AW'(3) : r_j + PT_AW'(1);
    assign hm_addr  = herm_addr(r_kind, r_j, 2'd0);
    assign hm_next  = herm_addr(r_kind, r_j, r_k + 2'd1);
    assign t_clamp  = r_t[VAL_W-1] ? 17'd0 :
                      ((r_t > 32'sd65536) ? 17'd65536 : r_t[16:0]);
    assign sx       = {3'b0, r_x};
    assign sx2      = {3'b0, r_x2};
    assign sx3      = {3'b0, r_x3};
    assign dx       = 33'(r_x1) - 33'(r_rdata);
    assign dt       = 33'(r_t) - 33'(r_rdata);
    assign rem2     = {r_rem[32:0], 1'b0};
    assign ge       = (rem2 >= {1'b0, r_dx});
    assign seg      = r_prod[PROD_W-1:16];

    assign mem_we   = (r_state == S_IDLE) && i_q_valid && (i_q_item.func == FUNC_WRITE);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_tready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_item.index] <= i_q_item.word;
        end
        r_rdata <= r_mem[mem_raddr];
        r_prod  <= mul_a * mul_b;
    end

    always_comb begin
        n_state = r_state;
        n_t = r_t;   n_kind = r_kind; n_used = r_used; n_n = r_n; n_i = r_i; n_j = r_j;
        n_x = r_x;   n_x2 = r_x2;     n_x3 = r_x3;     n_k = r_k; n_acc = r_acc;
        n_a = r_a;   n_x1 = r_x1;     n_rem = r_rem;   n_dx = r_dx; n_q = r_q;
        n_cnt = r_cnt; n_wide = r_wide; n_res = r_res; n_fb = r_fb;
        for (int m = 0; m < 4; m++) begin
            n_h[m] = r_h[m];
        end
        mem_raddr = '0;
        mul_a     = '0;
        mul_b     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && (i_q_item.func == FUNC_EVAL)) begin
                    n_t     = i_q_item.pos;
                    n_kind  = i_cfg.kind;
                    n_used  = used_sat;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_res = '0;
                n_fb  = 1'b1;
                case (r_kind)
                    KIND_LIN, KIND_HERM: begin
                        if (r_used == '0 || (r_kind == KIND_HERM && r_used[0])) begin
                            n_state = S_DONE;
                        end else if (r_t[VAL_W-1]) begin
                            mem_raddr = '0;
                            n_state   = S_RDRES;
                        end else begin
                            n_n     = (r_kind == KIND_LIN) ? PT_AW'(r_used - 1'b1)
                                                           : half - PT_AW'(1);
                            mul_a   = MUL_AW'(r_t);
                            mul_b   = MUL_BW'(n_n);
                            n_state = S_NT;
                        end
                    end
                    KIND_STEP: begin
                        if (r_used == '0) begin
                            n_state = S_DONE;
                        end else begin
                            mul_a   = {17'b0, t_clamp};
                            mul_b   = MUL_BW'(r_used - 1'b1);
                            n_state = S_NT;
                        end
                    end
                    KIND_KLIN, KIND_KSTEP, KIND_KHERM: begin
                        n_n = (r_kind == KIND_KHERM) ? third : half;
                        if (n_n == '0) begin
                            n_state = S_DONE;
                        end else begin
                            mem_raddr = '0;
                            n_state   = S_K0;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_NT: begin
                if (r_kind == KIND_STEP) begin
                    mem_raddr = r_prod[21:16];
                    n_state   = S_RDRES;
                end else if (seg >= 38'(r_n)) begin
                    mem_raddr = (r_kind == KIND_LIN) ? r_n : {r_n[PT_AW-2:0], 1'b0};
                    n_state   = S_RDRES;
                end else begin
                    n_x = {1'b0, r_prod[15:0]};
                    if (r_kind == KIND_LIN) begin
                        n_j     = r_prod[21:16];
                        n_state = S_LPRE;
                    end else begin
                        n_j     = {r_prod[20:16], 1'b0};
                        n_state = S_HX;
                    end
                end
            end
            S_LPRE: begin
                mem_raddr = addr_a;
                n_state   = S_LA;
            end
            S_LA: begin
                n_a       = r_rdata;
                mem_raddr = addr_b;
                n_state   = S_LB;
            end
            S_LB: begin
                mul_a   = MUL_AW'(r_rdata) - MUL_AW'(r_a);
                mul_b   = {3'b0, r_x};
                n_state = S_LM;
            end
            S_LM: begin
                n_wide  = WIDE_W'(r_prod >>> 16) + WIDE_W'(r_a);
                n_state = S_SAT;
            end
            S_HX: begin
                mul_a   = {17'b0, r_x};
                mul_b   = {3'b0, r_x};
                n_state = S_HX2;
            end
            S_HX2: begin
                n_x2    = r_prod[32:16];
                mul_a   = {17'b0, r_prod[32:16]};
                mul_b   = {3'b0, r_x};
                n_state = S_HX3;
            end
            S_HX3: begin
                n_x3    = r_prod[32:16];
                n_state = S_HB;
            end
            S_HB: begin
                // basis order matches point fetch order: p0, m0, p1, m1
                n_h[0]    = (sx3 <<< 1) - (sx2 + (sx2 <<< 1)) + 20'sd65536;
                n_h[1]    = sx3 - (sx2 <<< 1) + sx;
                n_h[2]    = (sx2 + (sx2 <<< 1)) - (sx3 <<< 1);
                n_h[3]    = sx3 - sx2;
                n_k       = '0;
                n_acc     = '0;
                mem_raddr = hm_addr;
                n_state   = S_HM;
            end
            S_HM: begin
                mul_a = MUL_AW'(r_rdata);
                mul_b = r_h[r_k];
                if (r_k != 2'd0) begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
                if (r_k == 2'd3) begin
                    n_state = S_HACC;
                end else begin
                    n_k       = r_k + 2'd1;
                    mem_raddr = hm_next;
                end
            end
            S_HACC: begin
                n_wide  = WIDE_W'((r_acc + ACC_W'(r_prod)) >>> 16);
                n_state = S_SAT;
            end
            S_K0: begin
                if (r_t <= r_rdata) begin
                    mem_raddr = PT_AW'(1);
                    n_state   = S_RDRES;
                end else begin
                    mem_raddr = last_key;
                    n_state   = S_KL;
                end
            end
            S_KL: begin
                if (r_t >= r_rdata) begin
                    mem_raddr = last_key + PT_AW'(1);
                    n_state   = S_RDRES;
                end else begin
                    n_i       = '0;
                    n_j       = '0;
                    mem_raddr = stride;
                    n_state   = S_KS;
                end
            end
            S_KS: begin
                if (r_t < r_rdata) begin
                    n_x1 = r_rdata;
                    if (r_kind == KIND_KSTEP) begin
                        mem_raddr = r_j + PT_AW'(1);
                        n_state   = S_RDRES;
                    end else begin
                        mem_raddr = r_j;
                        n_state   = S_KX0;
                    end
                end else if (7'(r_i) + 7'd2 < 7'(r_n)) begin
                    // advance to the next segment
                    n_i       = r_i + PT_AW'(1);
                    n_j       = r_j + stride;
                    mem_raddr = r_j + stride + stride;
                end else begin
                    n_res   = '0;
                    n_fb    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_KX0: begin
                if (dx <= 33'sd0 || dt <= 33'sd0 || dt >= dx) begin
                    n_x     = (dx <= 33'sd0 || dt <= 33'sd0) ? 17'd0 : 17'd65536;
                    n_state = (r_kind == KIND_KLIN) ? S_LPRE : S_HX;
                end else begin
                    n_rem   = 34'(dt);
                    n_dx    = dx;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? rem2 - {1'b0, r_dx} : rem2;
                n_q   = {r_q[14:0], ge};
                if (r_cnt == 4'd15) begin
                    n_x     = {1'b0, r_q[14:0], ge};
                    n_state = (r_kind == KIND_KLIN) ? S_LPRE : S_HX;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_RDRES: begin
                n_res   = r_rdata;
                n_fb    = 1'b0;
                n_state = S_DONE;
            end
            S_SAT: begin
                n_res   = sat32(r_wide);
                n_fb    = 1'b0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;   r_kind <= n_kind; r_used <= n_used; r_n <= n_n; r_i <= n_i; r_j <= n_j;
        r_x <= n_x;   r_x2 <= n_x2;     r_x3 <= n_x3;     r_k <= n_k; r_acc <= n_acc;
        r_a <= n_a;   r_x1 <= n_x1;     r_rem <= n_rem;   r_dx <= n_dx; r_q <= n_q;
        r_cnt <= n_cnt; r_wide <= n_wide; r_res <= n_res; r_fb <= n_fb;
        for (int m = 0; m < 4; m++) begin
            r_h[m] <= n_h[m];
        end
        if (out_load) begin
            r_oval <= r_res;
            r_ofb  <= r_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_value  = r_oval;
    assign o_fb     = r_ofb;

endmodule

// ===== rtl/keyframe_curve_evaluator_top.sv =====
// Keyframe curve evaluator top level: register port, stream front end and engine.
// Depends on kfce_pkg, kfce_front and kfce_back.
//
// Input stream: tuser is the function (0 writes point word, 1 evaluates);
// tdata carries point_index, point_word and position. A write item stores
// one word and gives no result; an evaluate item gives exactly one result
// word on the output stream: tdata is the Q16.16 value, tuser the
// default-zero flag.
// The keyed modes search their breakpoints with one store read per segment
// (at most 31), and keyed linear and Hermite interpolation use a 16-step
// ratio divider. One item is worked at a time; the engine takes the next
// item in the cycle after a result enters the result register, and a write
// item is stored without leaving the idle state.
// A two-word queue takes input while the engine is busy, and a result
// register holds a finished word while the receiver stalls, so the engine
// stops only when that register is still full.
// Reset clears control state and sets curve_kind to 0, points_used to 2; the
// point store is not cleared and must be written before it is read.
// Configure through the APB port only while the block is idle.
module keyframe_curve_evaluator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // point_index[5:0], point_word[37:6], position[69:38]
    input  logic        i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // curve_value[31:0]
    output logic        o_m_tuser,   // default_zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kfce_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [USED_W-1:0] r_used;
    t_cfg              cfg;
    t_item             s_item, q_item;
    logic              q_valid, q_pop, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_LIN;
            r_used <= USED_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_KIND) begin
                r_kind <= pwdata[KIND_W-1:0];
            end else begin
                r_used <= pwdata[USED_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_USED) ? {25'b0, r_used} : {29'b0, r_kind};

    assign cfg.kind = r_kind;
    assign cfg.used = r_used;

    assign s_item.func  = i_s_tuser;
    assign s_item.index = i_s_tdata[5:0];
    assign s_item.word  = i_s_tdata[37:6];
    assign s_item.pos   = i_s_tdata[69:38];

    kfce_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_item    (s_item),
        .o_ready   (o_s_tready),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    kfce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_cfg     (cfg),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_value   (o_m_tdata),
        .o_fb      (o_m_tuser)
    );

endmodule

// ===== rtl/kfce_checker.sv =====
// Port-level checks for the keyframe curve evaluator, bound to the top level.
// Depends on keyframe_curve_evaluator_top_macros.svh and kfce_pkg.
`include "keyframe_curve_evaluator_top_macros.svh"

module kfce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import kfce_pkg::*;

    logic out_stall, kind_wr, kind_rd;

    assign out_stall = o_m_tvalid && !i_m_tready;
    assign kind_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_KIND);
    assign kind_rd   = psel && !pwrite && (paddr[2] == REG_KIND);

    `KFCE_AST_NEXT(a_out_hold, out_stall, o_m_tvalid, "result word dropped while stalled")
    `KFCE_AST_NEXT(a_out_stable, out_stall, $stable(o_m_tdata) && $stable(o_m_tuser), "result changed")
    `KFCE_AST_NOW(a_fb_zero, o_m_tvalid && o_m_tuser, o_m_tdata == 32'd0, "fallback is not zero")
    `KFCE_AST_NEXT(a_kind_rb, kind_wr, !kind_rd || prdata[2:0] == $past(pwdata[2:0]), "kind readback")

endmodule

bind keyframe_curve_evaluator_top kfce_checker u_kfce_checker (.*);
